@@ rtl/core/bfg_pkg.sv @@
// Shared types and constants for the bilinear field gather block.
// No dependencies; used by the top level and its checker.
package bfg_pkg;

    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // pipeline depth between an accepted request and its result strobe
    localparam int PIPE_LAT = 6;

    localparam logic [2:0] CFG_GRID_COLS  = 3'd0;
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd1;
    localparam logic [2:0] CFG_INV_CELL_X = 3'd2;
    localparam logic [2:0] CFG_INV_CELL_Y = 3'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [5:0]         write_col;
        logic [5:0]         write_row;
        logic signed [31:0] field_bx;
        logic signed [31:0] field_by;
        logic signed [31:0] field_bz;
        logic signed [31:0] field_ex;
        logic signed [31:0] field_ey;
        logic signed [31:0] field_ez;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] e_x;
        logic signed [31:0] e_y;
        logic signed [31:0] e_z;
        logic               out_of_range;
    } t_res;

    // one grid point, six components: 0..5 = bx, by, bz, ex, ey, ez
    typedef logic [5:0][31:0] t_cell;

endpackage

@@ rtl/core/bilinear_field_gather_2d.sv @@
// Top level of the bilinear field gather: grid store and interpolation pipeline.
// Depends on bfg_pkg.
//
// Takes one request per cycle, writes and queries alike, and never stalls:
// o_busy is high only during reset and in the cycle after it. A query's
// result appears on o_res with o_done after the multiply, index/bank read,
// weights, products, sum and round steps; a grid write gives no result.
// The receiver cannot hold results off. The grid lives in four banks split
// by column and row parity, so the four neighbours of a cell come from four
// different banks in one read cycle; a write lands in the same pipeline
// stage as the reads, so a query sees every earlier write. Unwritten grid
// points read back as whatever the RAM holds. The user must write config
// through the plain write port only while idle; the block does not check.
module bilinear_field_gather_2d #(
    parameter int MAX_COLS   = bfg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = bfg_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = bfg_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bfg_pkg::t_req i_req,
    output logic          o_busy,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_wdata,
    output logic          o_done,
    output bfg_pkg::t_res o_res
);

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int HC  = (MAX_COLS + 1) / 2;
    localparam int HR  = (MAX_ROWS + 1) / 2;
    localparam int HCW = (HC > 1) ? $clog2(HC) : 1;
    localparam int HRW = (HR > 1) ? $clog2(HR) : 1;
    localparam int AW  = HCW + HRW;
    localparam int DEPTH = 2 ** AW;
    localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam longint SAT_HI_L = (longint'(1) << (VB - 1)) - 1;
    localparam longint SAT_LO_L = -(longint'(1) << (VB - 1));
    localparam logic signed [33:0] SAT_HI = 34'(SAT_HI_L);
    localparam logic signed [33:0] SAT_LO = 34'(SAT_LO_L);
    localparam logic signed [65:0] HALF_LSB = 66'sd2147483648;

    // ---------------- configuration ----------------
    logic [CNW-1:0] r_cols;
    logic [RNW-1:0] r_rows;
    logic [23:0]    r_inv_x, r_inv_y;
    logic [10:0]    cfg_sz;
    logic [CNW-1:0] n_cols;
    logic [RNW-1:0] n_rows;

    // sizes outside the legal range snap to the nearest end
    always_comb begin
        cfg_sz = 11'(i_cfg_wdata[6:0]);
        if (cfg_sz < 11'd2)
            n_cols = CNW'(2);
        else if (cfg_sz > 11'(MAX_COLS))
            n_cols = CNW'(MAX_COLS);
        else
            n_cols = CNW'(cfg_sz);
        if (cfg_sz < 11'd2)
            n_rows = RNW'(2);
        else if (cfg_sz > 11'(MAX_ROWS))
            n_rows = RNW'(MAX_ROWS);
        else
            n_rows = RNW'(cfg_sz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= CNW'(RST_COLS);
            r_rows  <= RNW'(RST_ROWS);
            r_inv_x <= 24'h010000;
            r_inv_y <= 24'h010000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfg_pkg::CFG_GRID_COLS:  r_cols  <= n_cols;
                bfg_pkg::CFG_GRID_ROWS:  r_rows  <= n_rows;
                bfg_pkg::CFG_INV_CELL_X: r_inv_x <= i_cfg_wdata;
                bfg_pkg::CFG_INV_CELL_Y: r_inv_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b1;
        else          r_busy <= 1'b0;
    end
    assign o_busy = r_busy;

    // ---------------- stage 1: scale positions ----------------
    logic                r_v1, r_kind1;
    logic [55:0]         r_sx, r_sy;
    logic [5:0]          r_wcol, r_wrow;
    bfg_pkg::t_cell      r_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_start && !r_busy;
    end

    always_ff @(posedge i_clk) begin
        r_kind1    <= i_req.kind;
        r_sx       <= 56'(i_req.pos_x) * 56'(r_inv_x);
        r_sy       <= 56'(i_req.pos_y) * 56'(r_inv_y);
        r_wcol     <= i_req.write_col;
        r_wrow     <= i_req.write_row;
        r_wdata[0] <= i_req.field_bx;
        r_wdata[1] <= i_req.field_by;
        r_wdata[2] <= i_req.field_bz;
        r_wdata[3] <= i_req.field_ex;
        r_wdata[4] <= i_req.field_ey;
        r_wdata[5] <= i_req.field_ez;
    end

    // ---------------- stage 2: cell index, bank access ----------------
    logic [23:0] ix, iy;
    logic [15:0] x1, y1, wcol16, wrow16;
    logic [16:0] xp1, yp1;
    logic        oor, x2nz, y2nz;
    logic        wr_en;
    logic [1:0]  wr_bank;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr [4];
    bfg_pkg::t_cell rd_data [4];

    always_comb begin
        ix   = r_sx[55:32];
        iy   = r_sy[55:32];
        oor  = (ix >= 24'(r_cols)) || (iy >= 24'(r_rows));
        x1   = r_sx[47:32];
        y1   = r_sy[47:32];
        xp1  = 17'(x1) + 17'd1;
        yp1  = 17'(y1) + 17'd1;
        // upper neighbour that wraps to index zero drops out
        x2nz = (xp1 != 17'(r_cols));
        y2nz = (yp1 != 17'(r_rows));
        wcol16  = 16'(r_wcol);
        wrow16  = 16'(r_wrow);
        wr_en   = r_v1 && (r_kind1 == bfg_pkg::KIND_WRITE)
                  && (11'(r_wcol) < 11'(MAX_COLS)) && (11'(r_wrow) < 11'(MAX_ROWS));
        wr_bank = {r_wcol[0], r_wrow[0]};
        wr_addr = {wcol16[HCW:1], wrow16[HRW:1]};
    end

    // bank b holds column parity b[1], row parity b[0]
    for (genvar b = 0; b < 4; b++) begin : g_bank
        bfg_pkg::t_cell mem [DEPTH];
        bfg_pkg::t_cell r_rd;
        logic [HCW-1:0] colh;
        logic [HRW-1:0] rowh;

        always_comb begin
            colh = (x1[0] == b[1]) ? x1[HCW:1] : xp1[HCW:1];
            rowh = (y1[0] == b[0]) ? y1[HRW:1] : yp1[HRW:1];
            rd_addr[b] = {colh, rowh};
        end

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b)))
                mem[wr_addr] <= r_wdata;
            r_rd <= mem[rd_addr[b]];
        end

        assign rd_data[b] = r_rd;
    end

    logic        r_v2, r_oor2, r_x2nz2, r_y2nz2, r_px2, r_py2;
    logic [15:0] r_fx2, r_fy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1 && (r_kind1 == bfg_pkg::KIND_QUERY);
    end

    always_ff @(posedge i_clk) begin
        r_oor2  <= oor;
        r_x2nz2 <= x2nz;
        r_y2nz2 <= y2nz;
        r_px2   <= x1[0];
        r_py2   <= y1[0];
        r_fx2   <= r_sx[31:16];
        r_fy2   <= r_sy[31:16];
    end

    // ---------------- stage 3: weights, neighbour select ----------------
    logic [16:0] ofx, ofy, fx17, fy17;
    logic [32:0] w [4];
    bfg_pkg::t_cell nb [4];

    always_comb begin
        fx17 = 17'(r_fx2);
        fy17 = 17'(r_fy2);
        ofx  = 17'h10000 - fx17;
        ofy  = 17'h10000 - fy17;
        w[0] = 33'(ofx * ofy);
        w[1] = r_y2nz2 ? 33'(ofx * fy17) : 33'd0;
        w[2] = r_x2nz2 ? 33'(fx17 * ofy) : 33'd0;
        w[3] = (r_x2nz2 && r_y2nz2) ? 33'(fx17 * fy17) : 33'd0;
        nb[0] = rd_data[{r_px2, r_py2}];
        nb[1] = r_y2nz2 ? rd_data[{r_px2, ~r_py2}] : '0;
        nb[2] = r_x2nz2 ? rd_data[{~r_px2, r_py2}] : '0;
        nb[3] = (r_x2nz2 && r_y2nz2) ? rd_data[{~r_px2, ~r_py2}] : '0;
    end

    logic           r_v3, r_oor3;
    logic [32:0]    r_w3 [4];
    bfg_pkg::t_cell r_nb3 [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        r_oor3 <= r_oor2;
        for (int n = 0; n < 4; n++) begin
            r_w3[n]  <= w[n];
            r_nb3[n] <= nb[n];
        end
    end

    // ---------------- stage 4: products ----------------
    logic               r_v4, r_oor4;
    logic signed [65:0] r_p4 [4][6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        r_oor4 <= r_oor3;
        for (int n = 0; n < 4; n++)
            for (int k = 0; k < 6; k++)
                r_p4[n][k] <= 66'($signed(r_nb3[n][k])) * 66'($signed({1'b0, r_w3[n]}));
    end

    // ---------------- stage 5: sums ----------------
    logic               r_v5, r_oor5;
    logic signed [65:0] r_s5 [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        r_oor5 <= r_oor4;
        for (int k = 0; k < 6; k++)
            r_s5[k] <= r_p4[0][k] + r_p4[1][k] + r_p4[2][k] + r_p4[3][k];
    end

    // ---------------- stage 6: round, saturate, output ----------------
    logic signed [65:0] rnd [6];
    logic signed [33:0] tq  [6];
    logic [31:0]        fin [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            rnd[k] = r_s5[k] + HALF_LSB;
            tq[k]  = rnd[k][65:32];
            if (tq[k] > SAT_HI)
                fin[k] = SAT_HI[31:0];
            else if (tq[k] < SAT_LO)
                fin[k] = SAT_LO[31:0];
            else
                fin[k] = tq[k][31:0];
            if (r_oor5)
                fin[k] = 32'd0;
        end
    end

    logic          r_done;
    bfg_pkg::t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        r_res.b_x          <= fin[0];
        r_res.b_y          <= fin[1];
        r_res.b_z          <= fin[2];
        r_res.e_x          <= fin[3];
        r_res.e_y          <= fin[4];
        r_res.e_z          <= fin[5];
        r_res.out_of_range <= r_oor5;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/core/bfg_checker.sv @@
// Port-level checks for bilinear_field_gather_2d, bound to the top level.
// Depends on bfg_pkg.
module bfg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input bfg_pkg::t_req i_req,
    input logic          o_busy,
    input logic          o_done,
    input bfg_pkg::t_res o_res
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy && !o_done)
        else $error("busy/done wrong after reset");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.out_of_range |->
            o_res.b_x == 32'd0 && o_res.b_y == 32'd0 && o_res.b_z == 32'd0 &&
            o_res.e_x == 32'd0 && o_res.e_y == 32'd0 && o_res.e_z == 32'd0)
        else $error("out of range result carries values");

    a_done_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy && i_req.kind == bfg_pkg::KIND_QUERY,
                         bfg_pkg::PIPE_LAT))
        else $error("result without matching query");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_start && !o_busy && i_req.kind == bfg_pkg::KIND_WRITE,
              bfg_pkg::PIPE_LAT) |-> !o_done)
        else $error("grid write produced a result");

endmodule

bind bilinear_field_gather_2d bfg_checker u_bfg_checker (.*);
